// ===== design/litl_pkg.sv =====
// Shared types and constants for the linear interpolation table lookup.
`default_nettype none
package litl_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int FRACTION_BITS = 24;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAG_W         = DATA_W + 1;
    localparam int PROD_W        = MAG_W + FRACTION_BITS;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_INDEX,
        S_READ_A,
        S_READ_B,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== design/litl_ram.sv =====
// Single-port-write, registered-read sample memory.
`default_nettype none
module litl_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/litl_mul.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none
module litl_mul (
    input  wire logic                                aclk,
    input  wire logic [litl_pkg::MAG_W-1:0]          mul_a,
    input  wire logic [litl_pkg::FRACTION_BITS-1:0]  mul_b,
    output logic      [litl_pkg::PROD_W-1:0]         prod_reg
);
    import litl_pkg::*;

    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

// ===== design/linear_interp_table_lookup.sv =====
// Linear interpolation table lookup: a load item (op 0) stores the next signed Q16.16
// sample, first_entry restarting the table at entry zero; loads past
// 1024 entries are dropped and flagged through table_full. A query item (op 1) gives
// a Q0.24 position and returns v[i] + floor((v[i+1]-v[i]) * f) at position times
// entry count, or zero with in_range low for position zero or the last interval.
// A query holds the block from its acceptance until its result is taken; a zero
// position or an out-of-range index goes straight to the output. The steps use one
// shared 33x24 multiplier twice, to scale the position and to weight the
// difference, and two reads of the single read port of the sample memory; s_ready
// is low meanwhile.
`default_nettype none
module linear_interp_table_lookup (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic                                s_first_entry,
    input  wire logic signed [litl_pkg::DATA_W-1:0]  s_entry_value,
    input  wire logic [litl_pkg::FRACTION_BITS-1:0]  s_position,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [litl_pkg::DATA_W-1:0]       m_result_value,
    output logic                                     m_in_range,
    output logic                                     m_table_full
);
    import litl_pkg::*;

    localparam int ROUND_W = PROD_W + 1;
    localparam int PART_W  = ROUND_W - FRACTION_BITS;
    localparam int SUM_W   = PART_W + 1;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [FRACTION_BITS-1:0] pos_reg, pos_next;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [DATA_W-1:0]        a_reg, a_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        res_reg, res_next;
    logic                     inr_reg, inr_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;

    logic [MAG_W-1:0]         mul_a;
    logic [FRACTION_BITS-1:0] mul_b;
    logic [PROD_W-1:0]        prod;

    logic [COUNT_W-1:0]       idx_full;
    logic [MAG_W-1:0]         diff;
    logic [ROUND_W-1:0]       prod_round;
    logic [PART_W-1:0]        part;
    logic [SUM_W-1:0]         a_ext;
    logic [SUM_W-1:0]         sum;

    litl_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    litl_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    assign idx_full   = prod[FRACTION_BITS +: COUNT_W];
    assign diff       = {rd_data[DATA_W-1], rd_data} - {a_reg[DATA_W-1], a_reg};
    assign prod_round = {1'b0, prod} + ROUND_W'((1 << FRACTION_BITS) - 1);
    assign part       = neg_reg ? prod_round[ROUND_W-1:FRACTION_BITS]
                                : {1'b0, prod[PROD_W-1:FRACTION_BITS]};
    assign a_ext      = {{(SUM_W-DATA_W){a_reg[DATA_W-1]}}, a_reg};
    assign sum        = neg_reg ? a_ext - {1'b0, part} : a_ext + {1'b0, part};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        frac_reg <= frac_next;
        idx_reg  <= idx_next;
        a_reg    <= a_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        inr_reg  <= inr_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        frac_next  = frac_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        inr_next   = inr_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = s_entry_value;
        rd_addr    = idx_reg;
        mul_a      = MAG_W'(count_reg);
        mul_b      = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOAD) begin
                        if (s_first_entry) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            count_next = COUNT_W'(1);
                            ovf_next   = 1'b0;
                        end else if (count_reg < COUNT_W'(TABLE_DEPTH)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + COUNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        pos_next = s_position;
                        if (s_position == '0) begin
                            res_next   = '0;
                            inr_next   = 1'b0;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_SCALE;
                        end
                    end
                end
            end
            S_SCALE: begin
                state_next = S_INDEX;
            end
            S_INDEX: begin
                frac_next = prod[FRACTION_BITS-1:0];
                if (({1'b0, idx_full} + (COUNT_W+1)'(1)) >= {1'b0, count_reg}) begin
                    res_next   = '0;
                    inr_next   = 1'b0;
                    state_next = S_OUT;
                end else begin
                    idx_next   = idx_full[ADDR_W-1:0];
                    rd_addr    = idx_full[ADDR_W-1:0];
                    state_next = S_READ_A;
                end
            end
            S_READ_A: begin
                a_next     = rd_data;
                rd_addr    = idx_reg + ADDR_W'(1);
                state_next = S_READ_B;
            end
            S_READ_B: begin
                neg_next   = diff[MAG_W-1];
                mag_next   = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
                state_next = S_MUL;
            end
            S_MUL: begin
                mul_a      = mag_reg;
                mul_b      = frac_reg;
                state_next = S_SUM;
            end
            S_SUM: begin
                res_next   = sum[DATA_W-1:0];
                inr_next   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_result_value = res_reg;
    assign m_in_range     = inr_reg;
    assign m_table_full   = ovf_reg;

endmodule
`default_nettype wire

// ===== tb/sv/linear_interp_table_lookup_test.sv =====
// Testbench for linear_interp_table_lookup: directed table plus random loads and lookups.
module linear_interp_table_lookup_test;
    import litl_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     in_range;
        logic                     full;
    } lookup_t;

    typedef struct packed {
        logic                     op;
        logic                     first;
        logic [DATA_W-1:0]        value;
        logic [FRACTION_BITS-1:0] pos;
        logic                     preset;
        lookup_t                  want;
    } lookup_row_t;

    localparam lookup_t OUT_OF_RANGE = '{32'sh0, 1'b0, 1'b0};
    localparam int      RANDOM_ITEMS = 600;
    localparam int      FILL_PHASE   = 2;

    localparam lookup_row_t DIRECTED [18] = '{
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h800000, 1'b1, OUT_OF_RANGE},
        '{OP_LOAD,  1'b1, 32'h7FFF_FFFF, 24'h000000, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h400000, 1'b1, OUT_OF_RANGE},
        '{OP_LOAD,  1'b0, 32'h8000_0000, 24'hFFFFFF, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h000000, 1'b1, OUT_OF_RANGE},
        '{OP_QUERY, 1'b1, 32'hFFFF_FFFF, 24'h000001, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h7FFFFF, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h800000, 1'b1, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'hFFFFFF, 1'b1, OUT_OF_RANGE},
        '{OP_LOAD,  1'b0, 32'h7FFF_FFFF, 24'h000000, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'hAAAAAB, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h555555, 1'b0, OUT_OF_RANGE},
        '{OP_LOAD,  1'b1, 32'h0000_0000, 24'h000000, 1'b0, OUT_OF_RANGE},
        '{OP_LOAD,  1'b0, 32'h0001_0000, 24'h000000, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h400000, 1'b1, '{32'sh0000_8000, 1'b1, 1'b0}},
        '{OP_LOAD,  1'b0, 32'hFFFF_FFFF, 24'h000000, 1'b0, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'hFFFFFF, 1'b1, OUT_OF_RANGE},
        '{OP_QUERY, 1'b0, 32'h0000_0000, 24'h800001, 1'b0, OUT_OF_RANGE}
    };

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic                            s_op          = OP_LOAD;
    logic                            s_first_entry = 1'b0;
    logic signed [DATA_W-1:0]        s_entry_value = '0;
    logic [FRACTION_BITS-1:0]        s_position    = '0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic signed [DATA_W-1:0]        m_result_value;
    logic                            m_in_range;
    logic                            m_table_full;

    logic [DATA_W-1:0] sample_model [TABLE_DEPTH];
    int unsigned       model_count = 0;
    logic              model_full  = 1'b0;
    lookup_t           pending_lookups [$];
    int                mismatch_count = 0;
    bit                steady_flow    = 1'b0;

    linear_interp_table_lookup u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_first_entry  (s_first_entry),
        .s_entry_value  (s_entry_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_in_range     (m_in_range),
        .m_table_full   (m_table_full)
    );

    always #2 aclk = ~aclk;

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic void store_sample(input logic restart, input logic [DATA_W-1:0] v);
        if (restart) begin
            model_count = 0;
            model_full  = 1'b0;
        end
        if (model_count < TABLE_DEPTH) begin
            sample_model[model_count] = v;
            model_count++;
        end else begin
            model_full = 1'b1;
        end
    endfunction

    function automatic lookup_t interpolate_sample(input logic [FRACTION_BITS-1:0] pos);
        lookup_t            r;
        logic [63:0]        scaled;
        logic [63:0]        idx;
        logic [63:0]        frac;
        logic [DATA_W-1:0]  a_raw;
        logic [DATA_W-1:0]  b_raw;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] sum;
        r.value    = '0;
        r.in_range = 1'b0;
        r.full     = model_full;
        scaled = 64'(pos) * 64'(model_count);
        idx    = scaled >> FRACTION_BITS;
        frac   = scaled & ((64'd1 << FRACTION_BITS) - 64'd1);
        if (pos != '0 && idx + 64'd1 < 64'(model_count)) begin
            a_raw = sample_model[idx[ADDR_W-1:0]];
            b_raw = sample_model[idx[ADDR_W-1:0] + 1'b1];
            lo    = {{32{a_raw[DATA_W-1]}}, a_raw};
            hi    = {{32{b_raw[DATA_W-1]}}, b_raw};
            // arithmetic shift gives the floor for negative slopes
            sum   = lo + (((hi - lo) * $signed(frac)) >>> FRACTION_BITS);
            r.value    = sum[DATA_W-1:0];
            r.in_range = 1'b1;
        end
        return r;
    endfunction

    task automatic put_item(input logic op, input logic first, input logic [DATA_W-1:0] value,
                            input logic [FRACTION_BITS-1:0] pos, input logic preset,
                            input lookup_t want);
        while (!steady_flow && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_first_entry <= first;
        s_entry_value <= value;
        s_position    <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_LOAD) begin
            store_sample(first, value);
        end else if (preset) begin
            pending_lookups.push_back(want);
        end else begin
            pending_lookups.push_back(interpolate_sample(pos));
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= aresetn && (steady_flow || $urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected item", '0, m_result_value);
            end else begin
                want = pending_lookups.pop_front();
                if (m_result_value !== want.value)
                    report_mismatch("result_value", want.value, m_result_value);
                if (m_in_range !== want.in_range)
                    report_mismatch("in_range", 32'(want.in_range), 32'(m_in_range));
                if (m_table_full !== want.full)
                    report_mismatch("table_full", 32'(want.full), 32'(m_table_full));
            end
        end
    end

    initial begin
        lookup_t                  left;
        int                       phase;
        int                       sent;
        int                       n_loads;
        int                       n_queries;
        int                       style;
        int                       waited;
        bit                       restart;
        logic [DATA_W-1:0]        val;
        logic [DATA_W-1:0]        prev;
        logic [FRACTION_BITS-1:0] pos;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[k])
            put_item(DIRECTED[k].op, DIRECTED[k].first, DIRECTED[k].value, DIRECTED[k].pos,
                     DIRECTED[k].preset, DIRECTED[k].want);

        sent  = 0;
        phase = 0;
        prev  = '0;
        while (sent < RANDOM_ITEMS) begin
            steady_flow = (sent >= 250 && sent < 380);
            style   = $urandom_range(2);
            restart = ($urandom_range(3) != 0);
            if (phase == FILL_PHASE)
                n_loads = TABLE_DEPTH + $urandom_range(6, 1);
            else if ($urandom_range(9) == 0)
                n_loads = 0;
            else
                n_loads = $urandom_range(24, 1);
            for (int j = 0; j < n_loads; j++) begin
                if ($urandom_range(11) == 0) begin
                    // stray lookup in the middle of a load burst
                    put_item(OP_QUERY, 1'($urandom_range(1)), $urandom(),
                             24'($urandom()), 1'b0, OUT_OF_RANGE);
                    sent++;
                end
                case (style)
                    0: val = $urandom();
                    1: val = prev + 32'($urandom_range(131072)) - 32'd65536;
                    default: val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                endcase
                prev = val;
                put_item(OP_LOAD, restart && j == 0, val, 24'($urandom()), 1'b0,
                         OUT_OF_RANGE);
                if (phase != FILL_PHASE)
                    sent++;
            end
            n_queries = $urandom_range(10, 1);
            for (int j = 0; j < n_queries; j++) begin
                case ($urandom_range(9))
                    0: pos = '0;
                    1: pos = 24'hFFFFFF - 24'($urandom_range(255));
                    default: pos = 24'($urandom());
                endcase
                put_item(OP_QUERY, 1'($urandom_range(1)), $urandom(), pos, 1'b0,
                         OUT_OF_RANGE);
                sent++;
            end
            phase++;
        end
        steady_flow = 1'b0;

        s_valid <= 1'b0;
        waited = 0;
        while (pending_lookups.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (16) @(posedge aclk);
        while (pending_lookups.size() != 0) begin
            left = pending_lookups.pop_front();
            report_mismatch("missing item", left.value, '0);
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
